// ===== hw/rtl/ess_pkg.sv =====
// Shared types, constants and field positions of the emitter slot scheduler.
`timescale 1ns / 1ps

package ess_pkg;

   // Defaults of the top-level sizing parameters.
   localparam int SLOT_COUNT_DEFAULT    = 64;
   localparam int PATTERN_DEPTH_DEFAULT = 256;

   // Request tdata layout, lowest bit first; the opcode travels in tuser.
   localparam int REQ_DATA_W   = 104;
   localparam int REQ_USER_W   = 2;
   localparam int REQ_SLOT_LSB = 0;
   localparam int REQ_PIDX_LSB = 6;
   localparam int REQ_OFFV_LSB = 14;
   localparam int REQ_LIFE_LSB = 30;
   localparam int REQ_CYC_LSB  = 46;
   localparam int REQ_TIME_LSB = 62;
   localparam int REQ_SLID_LSB = 82;

   // Response tdata layout, lowest bit first.
   localparam int RSP_DATA_W = 64;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Stored per-slot record: loop count, start frame, end frame.
   localparam int REC_W = 50;

   // Shared iterative divider.
   localparam int DIV_DVD_W = 33;
   localparam int DIV_CNT_W = 6;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_WRITE_OFFSET  = 2'd0;
   localparam opcode_type OP_WRITE_PATTERN = 2'd1;
   localparam opcode_type OP_QUERY         = 2'd2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_PATTERN_COUNT = 2'd0;
   localparam csr_index_type CSR_EMITTER_LIFE  = 2'd1;
   localparam csr_index_type CSR_ENDLESS       = 2'd2;
   localparam csr_index_type CSR_SLIDE_STEP    = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic clear_wr;
      logic mul;
      logic mod_start;
      logic pat_rd;
      logic div1_start;
      logic div1_take;
      logic cut_mark;
      logic div2_start;
      logic div2_take;
      logic out_load;
   } ess_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_query;
      logic div_busy;
      logic cyc_zero;
      logic cut_needed;
      logic out_free;
      logic clear_last;
   } ess_status_type;

endpackage

// ===== hw/rtl/ess_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ess_div
   import ess_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_DVD_W-1:0] dividend,
   input  logic [DIV_CNT_W-1:0] steps,
   input  logic [15:0]          divisor,
   output logic                 busy,
   output logic [15:0]          quotient,
   output logic [15:0]          remainder
);

   logic [DIV_DVD_W-1:0] dvd_ff, dvd_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [16:0]          rem_sh;
   logic [16:0]          rem_sub;
   logic                 ge;

   // Dividends shorter than the register are loaded left aligned, so the
   // quotient always collects in the low bits.
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DIV_DVD_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_DVD_W-2:0], ge};
         rem_in = ge ? rem_sub[15:0] : rem_sh[15:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = dvd_ff[15:0];
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/ess_datapath.sv =====
// Datapath: tables, configuration, slot records, query arithmetic and result register.
`timescale 1ns / 1ps

module ess_datapath
   import ess_pkg::*;
#(
   parameter int SLOT_COUNT    = SLOT_COUNT_DEFAULT,
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ess_cmd_type           cmd,
   output ess_status_type        status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int PAT_AW  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

   // Request fields.
   opcode_type  req_op;
   logic [5:0]  req_slot;
   logic [7:0]  req_pidx;
   logic [15:0] req_offv, req_life, req_cyc, req_slide;
   logic [19:0] req_time;
   logic [15:0] slot_ext, pidx_ext;
   logic [SLOT_AW-1:0] slot_addr;
   logic [PAT_AW-1:0]  pidx_addr;
   logic slot_ok, pidx_ok;

   assign req_op    = req_tuser;
   assign req_slot  = req_tdata[REQ_SLOT_LSB +: 6];
   assign req_pidx  = req_tdata[REQ_PIDX_LSB +: 8];
   assign req_offv  = req_tdata[REQ_OFFV_LSB +: 16];
   assign req_life  = req_tdata[REQ_LIFE_LSB +: 16];
   assign req_cyc   = req_tdata[REQ_CYC_LSB +: 16];
   assign req_time  = req_tdata[REQ_TIME_LSB +: 20];
   assign req_slide = req_tdata[REQ_SLID_LSB +: 16];
   assign slot_ext  = {10'd0, req_slot};
   assign pidx_ext  = {8'd0, req_pidx};
   assign slot_addr = slot_ext[SLOT_AW-1:0];
   assign pidx_addr = pidx_ext[PAT_AW-1:0];
   assign slot_ok   = 32'(req_slot) < SLOT_COUNT;
   assign pidx_ok   = 32'(req_pidx) < PATTERN_DEPTH;

   // Configuration registers.
   logic [8:0]  pcount_ff;
   logic [15:0] elife_ff;
   logic        endless_ff;
   logic [15:0] step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff  <= 9'd1;
         elife_ff   <= '0;
         endless_ff <= 1'b0;
         step_ff    <= 16'd1;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PATTERN_COUNT: pcount_ff  <= csr_wdata[8:0];
            CSR_EMITTER_LIFE:  elife_ff   <= csr_wdata;
            CSR_ENDLESS:       endless_ff <= csr_wdata[0];
            CSR_SLIDE_STEP:    step_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Memories.
   logic [15:0]      offset_mem [SLOT_COUNT];
   logic [31:0]      pat_mem    [PATTERN_DEPTH];
   logic [REC_W-1:0] rec_mem    [SLOT_COUNT];

   logic [15:0]        off_ff;
   logic [31:0]        pat_ff;
   logic [REC_W-1:0]   rec_rd_ff;
   logic [SLOT_AW-1:0] clr_ff;
   logic [SLOT_AW-1:0] rec_waddr;
   logic [REC_W-1:0]   rec_wdata;
   logic               rec_wen;

   // Query context latched at accept.
   logic [5:0]  slot_ff;
   logic [19:0] tnow_ff;
   logic [15:0] slide_ff;
   logic [SLOT_AW-1:0] qaddr_ff;
   logic [31:0] prod_ff;

   // Divider hookup.
   logic                 div_start;
   logic [DIV_DVD_W-1:0] div_dvd;
   logic [DIV_CNT_W-1:0] div_steps;
   logic [15:0]          div_dvs;
   logic                 div_busy;
   logic [15:0]          div_quot, div_rem;
   logic [15:0]          pcount_eff;
   logic [PAT_AW-1:0]    sel_addr;

   // Arithmetic.
   logic [15:0]        life_v, cyc_v, tint;
   logic               frac_nz;
   logic signed [16:0] a_s, t_s, t2_s, tsel_s;
   logic               tsel_neg;
   logic [16:0]        tsel_neg_val;
   logic [15:0]        tsel_mag;
   logic signed [16:0] q_s, r_s;
   logic signed [17:0] st_new;
   logic signed [18:0] en_new, tint_s;
   logic               hit_new;

   logic signed [16:0] loop_ff;
   logic signed [17:0] st_ff;
   logic signed [18:0] en_ff;
   logic               hit_ff, tneg_ff, cut_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  out_free;
   logic                  zero_cyc;
   logic                  exist_v, born_v;
   logic [REC_W-1:0]      rec_out;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (req_op == OP_WRITE_OFFSET && slot_ok) begin
            offset_mem[slot_addr] <= req_offv;
         end
         if (req_op == OP_WRITE_PATTERN && pidx_ok) begin
            pat_mem[pidx_addr] <= {req_life, req_cyc};
         end
         off_ff    <= offset_mem[slot_addr];
         rec_rd_ff <= rec_mem[slot_addr];
         slot_ff   <= req_slot;
         tnow_ff   <= req_time;
         slide_ff  <= req_slide;
         qaddr_ff  <= slot_addr;
      end
      if (cmd.pat_rd) begin
         pat_ff <= pat_mem[sel_addr];
      end
      if (rec_wen) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
   end

   // Clearing pass over the slot records after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + SLOT_AW'(1);
      end
   end

   always_comb begin
      rec_wen   = cmd.clear_wr || (cmd.out_load && !zero_cyc);
      rec_waddr = cmd.clear_wr ? clr_ff : qaddr_ff;
      rec_wdata = cmd.clear_wr ? '0 : rec_out;
   end

   // Pattern selection product.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= slide_ff * step_ff;
      end
   end

   always_comb begin
      if (pcount_ff == 9'd0) begin
         pcount_eff = 16'd1;
      end else if (32'(pcount_ff) > PATTERN_DEPTH) begin
         pcount_eff = 16'(PATTERN_DEPTH);
      end else begin
         pcount_eff = {7'd0, pcount_ff};
      end
   end

   assign sel_addr = div_rem[PAT_AW-1:0];

   // Elapsed whole frames, truncated toward zero.
   always_comb begin
      life_v  = pat_ff[31:16];
      cyc_v   = pat_ff[15:0];
      tint    = tnow_ff[19:4];
      frac_nz = |tnow_ff[3:0];
      a_s     = $signed({1'b0, tint}) - $signed({1'b0, off_ff});
      t_s     = a_s + $signed({16'd0, a_s[16] & frac_nz});
      t2_s    = $signed({1'b0, elife_ff}) - $signed({1'b0, off_ff});
      tsel_s  = cut_ff ? t2_s : t_s;
      tsel_neg     = tsel_s[16];
      tsel_neg_val = 17'(-tsel_s);
      tsel_mag     = tsel_neg ? tsel_neg_val[15:0] : tsel_s[15:0];
   end

   // Start frame is off + t - rem (rem carrying the sign of t), which equals
   // off + loop*cycle without a multiplier.
   always_comb begin
      q_s     = tsel_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
      r_s     = tsel_neg ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});
      st_new  = $signed({2'b0, off_ff}) + $signed({tsel_s[16], tsel_s})
                - $signed({r_s[16], r_s});
      en_new  = $signed({st_new[17], st_new}) + $signed({3'b0, life_v});
      tint_s  = $signed({3'b0, tint});
      hit_new = ($signed({st_new[17], st_new}) <= tint_s) && (en_new > tint_s);
   end

   always_comb begin
      div_start = cmd.mod_start || cmd.div1_start || cmd.div2_start;
      div_dvs   = cmd.mod_start ? pcount_eff : cyc_v;
      if (cmd.mod_start) begin
         div_dvd   = {1'b0, prod_ff} + DIV_DVD_W'(slot_ff);
         div_steps = DIV_CNT_W'(DIV_DVD_W);
      end else begin
         div_dvd   = {tsel_mag, 17'd0};
         div_steps = DIV_CNT_W'(16);
      end
   end

   ess_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .steps     (div_steps),
      .divisor   (div_dvs),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cut_ff <= 1'b0;
      end else if (cmd.cut_mark) begin
         cut_ff <= 1'b1;
      end
      if (cmd.div1_take) begin
         loop_ff <= q_s;
         st_ff   <= st_new;
         en_ff   <= en_new;
         hit_ff  <= hit_new;
         tneg_ff <= t_s[16];
      end else if (cmd.div2_take) begin
         st_ff <= st_new;
         en_ff <= en_new;
      end
   end

   // Flags and the outgoing record.
   always_comb begin
      zero_cyc = cyc_v == 16'd0;
      exist_v  = hit_ff && !cut_ff && !tneg_ff && !zero_cyc;
      born_v   = (endless_ff ? hit_ff : !cut_ff) && !tneg_ff && !zero_cyc;
      rec_out  = zero_cyc ? rec_rd_ff : {loop_ff, st_ff[15:0], en_ff[16:0]};
      out_free = !rsp_valid_ff || rsp_tready;
   end

   // The record keeps loop, start and end from the top down; the response lists them
   // from bit 8 upward.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {6'd0, rec_out[16:0], rec_out[32:17], rec_out[49:33],
                         born_v, exist_v, slot_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      status.req_query  = (req_op == OP_QUERY) && slot_ok;
      status.div_busy   = div_busy;
      status.cyc_zero   = zero_cyc;
      status.cut_needed = !endless_ff && (st_ff >= $signed({2'b0, elife_ff}));
      status.out_free   = out_free;
      status.clear_last = clr_ff == SLOT_AW'(SLOT_COUNT - 1);
   end

endmodule

// ===== hw/rtl/ess_ctrl.sv =====
// Controller state machine that sequences one item at a time through the datapath.
`timescale 1ns / 1ps

module ess_ctrl
   import ess_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output ess_cmd_type    cmd,
   input  ess_status_type status
);

   typedef enum logic [10:0] {
      ST_CLEAR     = 11'b000_0000_0001,
      ST_IDLE      = 11'b000_0000_0010,
      ST_MUL       = 11'b000_0000_0100,
      ST_MOD_GO    = 11'b000_0000_1000,
      ST_MOD_WAIT  = 11'b000_0001_0000,
      ST_DIV1_GO   = 11'b000_0010_0000,
      ST_DIV1_WAIT = 11'b000_0100_0000,
      ST_CUT       = 11'b000_1000_0000,
      ST_DIV2_GO   = 11'b001_0000_0000,
      ST_DIV2_WAIT = 11'b010_0000_0000,
      ST_OUT       = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.req_query) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_MOD_GO;
         end
         ST_MOD_GO: begin
            cmd.mod_start = 1'b1;
            state_in      = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (!status.div_busy) begin
               cmd.pat_rd = 1'b1;
               state_in   = ST_DIV1_GO;
            end
         end
         ST_DIV1_GO: begin
            if (status.cyc_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.div1_start = 1'b1;
               state_in       = ST_DIV1_WAIT;
            end
         end
         ST_DIV1_WAIT: begin
            if (!status.div_busy) begin
               cmd.div1_take = 1'b1;
               state_in      = ST_CUT;
            end
         end
         ST_CUT: begin
            if (status.cut_needed) begin
               cmd.cut_mark = 1'b1;
               state_in     = ST_DIV2_GO;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DIV2_GO: begin
            cmd.div2_start = 1'b1;
            state_in       = ST_DIV2_WAIT;
         end
         ST_DIV2_WAIT: begin
            if (!status.div_busy) begin
               cmd.div2_take = 1'b1;
               state_in      = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/emitter_slot_scheduler.sv =====
// Top level of the emitter slot scheduler: controller, datapath and the stream ports.
`timescale 1ns / 1ps

// The emitter slot scheduler keeps a per-slot emission offset table, a per-pattern
// table of particle life and respawn cycle, and a per-slot record of the last loop
// count, start frame and end frame. Items on the request stream either load a table
// entry (no response) or query a slot at a time given in sixteenths of a frame, and
// the unused opcode is taken without a response; each query returns one response
// item with the loop count, the start and end frames of the current life and the
// exist and born flags. Items are handled one at a time and their cost is set by a
// single shared divider that retires one bit per cycle: a query runs the 33-bit
// pattern-select modulo and then the 16-bit loop division, adds a second 16-bit
// division when the emitter-life cutoff forces one, and skips the loop division when
// the selected pattern has a zero cycle; it may also wait for the response register
// to drain. The response register lets the next item be accepted while a response
// is still waiting. After reset the block clears its slot records, one slot per
// cycle, before it accepts the first item; configuration writes are taken at any
// time but are meant to be issued only while the block is idle.

module emitter_slot_scheduler
   import ess_pkg::*;
#(
   parameter int SLOT_COUNT    = SLOT_COUNT_DEFAULT,
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata fields from bit 0: slot[5:0], pattern_index[13:6], offset_value[29:14],
   // pattern_life[45:30], pattern_cycle[61:46], time_now[81:62], slide[97:82], zero pad.
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // tuser fields from bit 0: opcode[1:0].
   input  logic [REQ_USER_W-1:0]  req_tuser,
   // Response stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata fields from bit 0: slot_out[5:0], exist[6], born[7], loop_count[24:8],
   // start_time[40:25], end_time[57:41], zero pad.
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // Configuration write port.
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ess_cmd_type    cmd;
   ess_status_type status;

   // The controller owns the request handshake and sequences each item.
   ess_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // The datapath holds every table, the divider and the response register.
   ess_datapath #(
      .SLOT_COUNT    (SLOT_COUNT),
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the emitter slot scheduler: directed table, random phases.
`timescale 1ns / 1ps

// The testbench drives the request stream of the emitter slot scheduler and checks every
// response item against a predictor of its own. The predictor keeps a private copy of the
// offset table, the pattern tables, the per-slot records and the four registers. It runs
// when a request item is accepted and queues the response that item must produce.
//
// The run has two parts. The first is a directed table. It covers the reset record, the
// field extremes, every opcode, a zero respawn cycle, the emitter-life cutoff, a query
// that lands before the slot offset, and pattern counts of zero and above the table depth.
// The second is eight random phases. Each phase starts from an idle block with a new set
// of register values, extremes among them. Queries are only made for slots and patterns
// that were written, so the random part writes any missing entry just before the query
// that needs it.
//
// Both stream sides draw a random wait for every item. Every third phase runs without
// waits. Each phase boundary drains all outstanding responses before the registers
// change.
module tb_top;
   import ess_pkg::*;

   localparam int          CLK_HALF_NS  = 6;
   localparam int          RESET_CYCLES = 6;
   // This margin covers any item still in flight once the last response has arrived,
   // even a query that needs the cutoff division.
   localparam int          DRAIN_CYCLES = 100;
   localparam int          PHASES       = 8;
   localparam int          PHASE_ITEMS  = 250;
   localparam int          NSLOTS       = SLOT_COUNT_DEFAULT;
   localparam int          NPATTERNS    = PATTERN_DEPTH_DEFAULT;
   // Opcode 3 has no function; the block must swallow it without a response.
   localparam opcode_type  OP_UNUSED    = 2'd3;

   // One request item, with its fields unpacked.
   typedef struct {
      opcode_type  op;
      logic [5:0]  slot;
      logic [7:0]  pidx;
      logic [15:0] offv;
      logic [15:0] life;
      logic [15:0] cyc;
      logic [19:0] tnow;
      logic [15:0] slide;
   } sched_req_type;

   // One response item, with its fields unpacked.
   typedef struct {
      logic [5:0]  slot;
      logic        exist;
      logic        born;
      logic [16:0] loop_count;
      logic [15:0] start_time;
      logic [16:0] end_time;
   } sched_rsp_type;

   // Per-slot record, held the way the block keeps it between queries.
   typedef struct {
      int          loop_v;
      logic [15:0] start_v;
      logic [16:0] end_v;
      logic        exist;
      logic        born;
   } slot_rec_type;

   // One row of the directed table: a register write, or an item with an optional
   // hand-computed response.
   typedef struct {
      bit            is_csr;
      csr_index_type csr_idx;
      logic [15:0]   csr_val;
      sched_req_type item;
      bit            typed;
      sched_rsp_type want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor state.
   logic [15:0]   offset_mem [NSLOTS];
   logic [15:0]   life_mem [NPATTERNS];
   logic [15:0]   cycle_mem [NPATTERNS];
   bit            offset_known [NSLOTS];
   bit            pattern_known [NPATTERNS];
   slot_rec_type  slot_rec [NSLOTS];
   logic [8:0]    cfg_pattern_count;
   logic [15:0]   cfg_emitter_life;
   logic          cfg_endless;
   logic [15:0]   cfg_slide_step;

   // Responses that are still owed, oldest first.
   sched_rsp_type pending_slot_results [$];
   int            mismatch_count = 0;
   // When set, neither stream side inserts waits.
   bit            no_idle = 1'b0;
   // Rows of the directed table, in the order they are sent.
   stim_row_type  directed [$];

   emitter_slot_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #CLK_HALF_NS clock = 1'b1;
      #CLK_HALF_NS clock = 1'b0;
   end

   // Pattern selected for a query. A count of zero behaves as one, and a count above the
   // table depth behaves as the depth.
   function automatic int unsigned pattern_select(input logic [5:0] slot,
                                                  input logic [15:0] slide);
      longint unsigned cnt;
      longint unsigned s;
      longint unsigned r;
      longint unsigned k;
      cnt = cfg_pattern_count;
      s   = slot;
      r   = slide;
      k   = cfg_slide_step;
      if (cnt == 0) begin
         cnt = 1;
      end
      if (cnt > NPATTERNS) begin
         cnt = NPATTERNS;
      end
      return int'((s + r * k) % cnt);
   endfunction

   // Applies one accepted item to the predictor state. Returns 1 and the response when
   // the item produces one.
   function automatic bit slot_schedule_result(input sched_req_type it,
                                               output sched_rsp_type r);
      int unsigned sel;
      int          s;
      longint      off;
      longint      life;
      longint      cyc;
      longint      tn;
      longint      elife;
      longint      t;
      longint      lp;
      longint      st;
      longint      en;
      r = '{default: '0};
      s = int'(it.slot);
      case (it.op)
         OP_WRITE_OFFSET: begin
            offset_mem[s]   = it.offv;
            offset_known[s] = 1'b1;
            return 1'b0;
         end
         OP_WRITE_PATTERN: begin
            life_mem[it.pidx]      = it.life;
            cycle_mem[it.pidx]     = it.cyc;
            pattern_known[it.pidx] = 1'b1;
            return 1'b0;
         end
         OP_QUERY: begin
         end
         default: begin
            return 1'b0;
         end
      endcase

      sel   = pattern_select(it.slot, it.slide);
      off   = offset_mem[s];
      life  = life_mem[sel];
      cyc   = cycle_mem[sel];
      tn    = it.tnow;
      elife = cfg_emitter_life;
      slot_rec[s].exist = 1'b0;
      slot_rec[s].born  = 1'b0;
      // With a zero cycle the stored loop and frames stand; only the flags drop.
      if (cyc != 0) begin
         // Both divisions truncate toward zero, also for times before the offset.
         t  = (tn - off * 16) / 16;
         lp = t / cyc;
         st = lp * cyc + off;
         en = st + life;
         slot_rec[s].loop_v = int'(lp);
         if (st * 16 <= tn && en * 16 > tn) begin
            slot_rec[s].exist = 1'b1;
            slot_rec[s].born  = 1'b1;
         end
         if (!cfg_endless) begin
            if (st >= elife) begin
               // Past the emitter life: the frames come from the last spawn before the
               // cutoff, while the loop count keeps the uncut value.
               st = ((elife - off) / cyc) * cyc + off;
               en = st + life;
               slot_rec[s].exist = 1'b0;
               slot_rec[s].born  = 1'b0;
            end else begin
               slot_rec[s].born = 1'b1;
            end
         end
         if (t < 0) begin
            slot_rec[s].exist = 1'b0;
            slot_rec[s].born  = 1'b0;
         end
         slot_rec[s].start_v = st[15:0];
         slot_rec[s].end_v   = en[16:0];
      end

      r.slot       = it.slot;
      r.exist      = slot_rec[s].exist;
      r.born       = slot_rec[s].born;
      r.loop_count = slot_rec[s].loop_v[16:0];
      r.start_time = slot_rec[s].start_v;
      r.end_time   = slot_rec[s].end_v;
      return 1'b1;
   endfunction

   // Sends one item after a random wait and queues its response once it is accepted.
   // A typed response replaces the predicted one; the predictor still sees the item.
   task automatic issue(input sched_req_type it, input bit typed, input sched_rsp_type want);
      int                    gap;
      logic [REQ_DATA_W-1:0] d;
      sched_rsp_type         got;
      sched_rsp_type         owed;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      d = '0;
      d[REQ_SLOT_LSB +: 6]  = it.slot;
      d[REQ_PIDX_LSB +: 8]  = it.pidx;
      d[REQ_OFFV_LSB +: 16] = it.offv;
      d[REQ_LIFE_LSB +: 16] = it.life;
      d[REQ_CYC_LSB +: 16]  = it.cyc;
      d[REQ_TIME_LSB +: 20] = it.tnow;
      d[REQ_SLID_LSB +: 16] = it.slide;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= d;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (slot_schedule_result(it, got)) begin
         if (typed) begin
            owed = want;
         end else begin
            owed = got;
         end
         pending_slot_results = {pending_slot_results, owed};
      end
   endtask

   // Stops sending, waits for every owed response, then lets any write in flight finish.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_slot_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_PATTERN_COUNT: cfg_pattern_count = val[8:0];
         CSR_EMITTER_LIFE:  cfg_emitter_life  = val;
         CSR_ENDLESS:       cfg_endless       = val[0];
         CSR_SLIDE_STEP:    cfg_slide_step    = val;
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   function automatic stim_row_type row_req(input opcode_type op, input int slot,
                                            input int pidx, input int offv, input int life,
                                            input int cyc, input int tnow, input int slide);
      stim_row_type r;
      r            = '{default: '0};
      r.item.op    = op;
      r.item.slot  = 6'(slot);
      r.item.pidx  = 8'(pidx);
      r.item.offv  = 16'(offv);
      r.item.life  = 16'(life);
      r.item.cyc   = 16'(cyc);
      r.item.tnow  = 20'(tnow);
      r.item.slide = 16'(slide);
      return r;
   endfunction

   function automatic stim_row_type row_csr(input csr_index_type idx, input int val);
      stim_row_type r;
      r         = '{default: '0};
      r.is_csr  = 1'b1;
      r.csr_idx = idx;
      r.csr_val = 16'(val);
      return r;
   endfunction

   // Attaches a hand-computed response to a query row.
   function automatic stim_row_type with_result(input stim_row_type r, input bit ex,
                                                input bit bn, input int lp, input int st,
                                                input int en);
      stim_row_type o;
      o                 = r;
      o.typed           = 1'b1;
      o.want.slot       = r.item.slot;
      o.want.exist      = ex;
      o.want.born       = bn;
      o.want.loop_count = 17'(lp);
      o.want.start_time = 16'(st);
      o.want.end_time   = 17'(en);
      return o;
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(input stim_row_type r);
      directed = {directed, r};
   endfunction

   function automatic logic [15:0] random_offset();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         return 16'($urandom_range(0, 3000));
      end else if (r < 8) begin
         return 16'($urandom);
      end else if (r == 8) begin
         return 16'h0000;
      end
      return 16'hFFFF;
   endfunction

   function automatic logic [15:0] random_life();
      return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 200)) : 16'($urandom);
   endfunction

   function automatic logic [15:0] random_cycle();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 16'h0000;
      end else if (r < 7) begin
         return 16'($urandom_range(1, 100));
      end
      return 16'($urandom);
   endfunction

   // Response side: a random stall before each item, then a check against the oldest
   // owed response.
   initial begin
      int            stall;
      sched_rsp_type got;
      sched_rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got.slot       = rsp_tdata[5:0];
         got.exist      = rsp_tdata[6];
         got.born       = rsp_tdata[7];
         got.loop_count = rsp_tdata[24:8];
         got.start_time = rsp_tdata[40:25];
         got.end_time   = rsp_tdata[57:41];
         if (pending_slot_results.size() == 0) begin
            $display("%0t: unexpected slot result: expected none, actual %h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_slot_results.pop_front();
            check_field("slot_out", want.slot, got.slot);
            check_field("exist", want.exist, got.exist);
            check_field("born", want.born, got.born);
            check_field("loop_count", want.loop_count, got.loop_count);
            check_field("start_time", want.start_time, got.start_time);
            check_field("end_time", want.end_time, got.end_time);
         end
      end
   end

   // Stimulus: reset, the directed table, then the random phases.
   initial begin
      sched_req_type it;
      sched_req_type fill;
      sched_rsp_type none;
      int unsigned   sel;
      int            count;
      int            roll;
      longint        tq;
      logic [8:0]    pc;
      logic [15:0]   el;
      logic          en;
      logic [15:0]   step;

      none = '{default: '0};
      for (int i = 0; i < NSLOTS; i++) begin
         slot_rec[i]     = '{default: '0};
         offset_known[i] = 1'b0;
         offset_mem[i]   = '0;
      end
      for (int i = 0; i < NPATTERNS; i++) begin
         pattern_known[i] = 1'b0;
         life_mem[i]      = '0;
         cycle_mem[i]     = '0;
      end
      cfg_pattern_count = 9'd1;
      cfg_emitter_life  = 16'd0;
      cfg_endless       = 1'b0;
      cfg_slide_step    = 16'd1;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Under the reset registers: one pattern and a cutoff at frame zero.
      add_row(row_req(OP_WRITE_PATTERN, 0, 0, 0, 10, 0, 0, 0));
      add_row(row_req(OP_WRITE_OFFSET, 0, 0, 0, 0, 0, 0, 0));
      // Zero cycle on a fresh slot returns the cleared record.
      add_row(with_result(row_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0),
                          0, 0, 0, 0, 0));
      add_row(row_req(OP_WRITE_PATTERN, 0, 0, 0, 'hFFFF, 'hFFFF, 0, 0));
      add_row(row_req(OP_WRITE_OFFSET, 63, 0, 'hFFFF, 0, 0, 0, 0));
      // All extremes: the cutoff pulls the start back one full cycle.
      add_row(with_result(row_req(OP_QUERY, 63, 0, 0, 0, 0, 'hFFFFF, 'hFFFF),
                          0, 0, 0, 0, 'hFFFF));
      add_row(row_req(OP_QUERY, 0, 0, 0, 0, 0, 'hFFFFF, 'hFFFF));
      // A zero cycle after a real one must keep the stored frames.
      add_row(row_req(OP_WRITE_PATTERN, 0, 0, 0, 20, 0, 0, 0));
      add_row(row_req(OP_QUERY, 0, 0, 0, 0, 0, 100, 0));
      add_row(row_req(OP_UNUSED, 'h3F, 'hFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFFF, 'hFFFF));
      // Endless emitter, full pattern count, largest slide step.
      add_row(row_csr(CSR_PATTERN_COUNT, 256));
      add_row(row_csr(CSR_EMITTER_LIFE, 'hFFFF));
      add_row(row_csr(CSR_ENDLESS, 1));
      add_row(row_csr(CSR_SLIDE_STEP, 'hFFFF));
      add_row(row_req(OP_WRITE_OFFSET, 5, 0, 100, 0, 0, 0, 0));
      add_row(row_req(OP_WRITE_PATTERN, 0, 5, 0, 7, 10, 0, 0));
      add_row(with_result(row_req(OP_QUERY, 5, 0, 0, 0, 0, 1600, 0),
                          1, 1, 0, 100, 107));
      add_row(with_result(row_req(OP_QUERY, 5, 0, 0, 0, 0, 2015, 0),
                          1, 1, 2, 120, 127));
      // Between two lives: neither alive nor born on an endless emitter.
      add_row(with_result(row_req(OP_QUERY, 5, 0, 0, 0, 0, 1888, 0),
                          0, 0, 1, 110, 117));
      // Finite emitter stopping at frame 115.
      add_row(row_csr(CSR_ENDLESS, 0));
      add_row(row_csr(CSR_EMITTER_LIFE, 115));
      add_row(with_result(row_req(OP_QUERY, 5, 0, 0, 0, 0, 2000, 0),
                          0, 0, 2, 110, 117));
      // A time before the slot offset gives a negative loop and no flags.
      add_row(row_req(OP_QUERY, 5, 0, 0, 0, 0, 800, 0));
      // A pattern count of zero acts as one.
      add_row(row_csr(CSR_PATTERN_COUNT, 0));
      add_row(row_req(OP_WRITE_PATTERN, 0, 0, 0, 20, 30, 0, 0));
      add_row(with_result(row_req(OP_QUERY, 0, 0, 0, 0, 0, 496, 'hABCD),
                          1, 1, 1, 30, 50));
      // A pattern count above the table depth acts as the depth.
      add_row(row_csr(CSR_PATTERN_COUNT, 511));
      add_row(row_csr(CSR_SLIDE_STEP, 1));
      add_row(row_req(OP_QUERY, 5, 0, 0, 0, 0, 1700, 256));
      add_row(row_req(OP_WRITE_PATTERN, 0, 255, 0, 0, 1, 0, 0));
      add_row(row_req(OP_QUERY, 0, 0, 0, 0, 0, 333, 255));

      foreach (directed[i]) begin
         if (directed[i].is_csr) begin
            wait_drained();
            csr_write(directed[i].csr_idx, directed[i].csr_val);
         end else begin
            issue(directed[i].item, directed[i].typed, directed[i].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // Registers change only on an idle block; this also holds the sender back until
         // every owed response is in.
         wait_drained();
         case (phase)
            0: begin
               pc = 9'd1;   el = 16'd0;     en = 1'b0; step = 16'd1;
            end
            1: begin
               pc = 9'd256; el = 16'hFFFF;  en = 1'b1; step = 16'hFFFF;
            end
            2: begin
               pc = 9'd0;   el = 16'($urandom_range(0, 4000)); en = 1'b0; step = 16'd0;
            end
            3: begin
               pc = 9'd511; el = 16'($urandom_range(0, 4000)); en = 1'b0;
               step = 16'($urandom);
            end
            default: begin
               pc = $urandom_range(0, 1) ? 9'($urandom_range(1, 256))
                                         : 9'($urandom_range(1, 8));
               el   = 16'($urandom_range(0, 4000));
               en   = 1'($urandom_range(0, 1));
               step = 16'($urandom);
            end
         endcase
         csr_write(CSR_PATTERN_COUNT, 16'(pc));
         csr_write(CSR_EMITTER_LIFE, el);
         csr_write(CSR_ENDLESS, 16'(en));
         csr_write(CSR_SLIDE_STEP, step);
         no_idle = (phase % 3 == 2);

         count = 0;
         while (count < PHASE_ITEMS) begin
            roll     = $urandom_range(0, 99);
            it.op    = OP_QUERY;
            it.slot  = 6'($urandom);
            it.pidx  = 8'($urandom);
            it.offv  = 16'($urandom);
            it.life  = 16'($urandom);
            it.cyc   = 16'($urandom);
            it.tnow  = 20'($urandom);
            it.slide = 16'($urandom);
            if (roll < 8) begin
               it.op   = OP_WRITE_OFFSET;
               it.offv = random_offset();
               issue(it, 1'b0, none);
               count++;
            end else if (roll < 16) begin
               it.op = OP_WRITE_PATTERN;
               // For counts of 2 to 256, half the pattern writes aim at selectable entries.
               if ($urandom_range(0, 1) && pc > 1 && pc <= NPATTERNS) begin
                  it.pidx = 8'($urandom_range(0, pc - 1));
               end
               it.life = random_life();
               it.cyc  = random_cycle();
               issue(it, 1'b0, none);
               count++;
            end else if (roll < 19) begin
               it.op = OP_UNUSED;
               issue(it, 1'b0, none);
            end else begin
               // A few slots take most queries so that their records carry over.
               if ($urandom_range(0, 1)) begin
                  it.slot = 6'($urandom_range(0, 7));
               end
               fill = it;
               if (!offset_known[it.slot]) begin
                  fill.op   = OP_WRITE_OFFSET;
                  fill.offv = random_offset();
                  issue(fill, 1'b0, none);
                  count++;
               end
               sel = pattern_select(it.slot, it.slide);
               if (!pattern_known[sel]) begin
                  fill.op   = OP_WRITE_PATTERN;
                  fill.pidx = 8'(sel);
                  fill.life = random_life();
                  fill.cyc  = random_cycle();
                  issue(fill, 1'b0, none);
                  count++;
               end
               // Most times fall near the slot offset, where loops and the cutoff matter.
               if ($urandom_range(0, 9) >= 4) begin
                  tq = longint'(offset_mem[it.slot]) * 16 + $urandom_range(0, 48000)
                       - $urandom_range(0, 640);
                  if (tq < 0) begin
                     tq = 0;
                  end
                  if (tq > 'hFFFFF) begin
                     tq = 'hFFFFF;
                  end
                  it.tnow = tq[19:0];
               end
               issue(it, 1'b0, none);
               count++;
            end
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, including the record clearing pass
   // after reset.
   initial begin
      #20_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ess_pkg.sv
hw/rtl/ess_div.sv
hw/rtl/ess_datapath.sv
hw/rtl/ess_ctrl.sv
hw/rtl/emitter_slot_scheduler.sv
tb/tb_top.sv
